@@ hdl/nit_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the command code table of the NEC IR transmitter.
// No dependencies; every other file in hdl/ except nit_queue imports this package.
package nit_pkg;

  // Input opcodes, carried on s_tuser.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_TABLE = 2'd1;
  localparam opcode_t OP_RAW   = 2'd2;
  localparam opcode_t OP_NOP   = 2'd3;

  // Result status codes, carried on m_tuser.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_ACCEPT  = 2'd1;
  localparam status_t ST_INVALID = 2'd2;
  localparam status_t ST_BUSY    = 2'd3;

  // Configuration register indexes.
  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_HEADER_MARK  = 3'd0;
  localparam reg_index_t REG_HEADER_SPACE = 3'd1;
  localparam reg_index_t REG_BIT_MARK     = 3'd2;
  localparam reg_index_t REG_ONE_SPACE    = 3'd3;
  localparam reg_index_t REG_ZERO_SPACE   = 3'd4;
  localparam reg_index_t REG_TRAILER_MARK = 3'd5;
  localparam reg_index_t REG_REPEAT_GAP   = 3'd6;
  localparam reg_index_t REG_REPEAT_COUNT = 3'd7;

  localparam int DUR_W = 17;
  typedef logic [DUR_W-1:0] dur_t;

  // Number of valid entries in the command table.
  localparam logic [4:0] COMMAND_COUNT = 5'd10;

  // Classified command kinds passed from the front end to the back end.
  typedef logic [2:0] cmd_kind_t;
  localparam cmd_kind_t CMD_NOP       = 3'd0;
  localparam cmd_kind_t CMD_TICK      = 3'd1;
  localparam cmd_kind_t CMD_RAW       = 3'd2;
  localparam cmd_kind_t CMD_TABLE     = 3'd3;
  localparam cmd_kind_t CMD_BAD_INDEX = 3'd4;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] code;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  // Command table; entries past the tenth read as zero.
  function automatic logic [31:0] code_rom(input logic [3:0] idx);
    logic [31:0] code;
    unique case (idx)
      4'd0:    code = 32'h20DF10EF;
      4'd1:    code = 32'h20DF10EF;
      4'd2:    code = 32'h20DF08F7;
      4'd3:    code = 32'h20DF0CF3;
      4'd4:    code = 32'h20DF0EF1;
      4'd5:    code = 32'h20DF40BF;
      4'd6:    code = 32'h20DFC03F;
      4'd7:    code = 32'h20DF8877;
      4'd8:    code = 32'h20DF48B7;
      4'd9:    code = 32'h20DFC837;
      default: code = 32'h0;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/nit_front.sv @@
`timescale 1ns / 1ps
// Front end: decodes an incoming request and looks up table codes.
// Depends on nit_pkg.
module nit_front (
  input  nit_pkg::opcode_t opcode,
  input  logic [3:0]       command_index,
  input  logic [31:0]      raw_code,
  output nit_pkg::cmd_t    cmd
);
  import nit_pkg::*;

  // Classify the request and pick the code it will send.
  always_comb begin
    cmd.kind = CMD_NOP;
    cmd.code = raw_code;
    unique case (opcode)
      OP_TICK: cmd.kind = CMD_TICK;
      OP_TABLE: begin
        if ({1'b0, command_index} >= COMMAND_COUNT) begin
          cmd.kind = CMD_BAD_INDEX;
        end else begin
          cmd.kind = CMD_TABLE;
          cmd.code = code_rom(command_index);
        end
      end
      OP_RAW: cmd.kind = CMD_RAW;
      default: cmd.kind = CMD_NOP;
    endcase
  end

endmodule

@@ hdl/nit_queue.sv @@
`timescale 1ns / 1ps
// Small FIFO that decouples the front end from the back end.
// No package dependency; width and depth come from parameters.
module nit_queue #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/nit_back.sv @@
`timescale 1ns / 1ps
// Back end: configuration registers, the NEC frame sequencer and the result
// output register. Depends on nit_pkg.
module nit_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  nit_pkg::reg_index_t cfg_index,
  input  nit_pkg::dur_t      cfg_data,
  input  logic               cmd_valid,
  input  nit_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output nit_pkg::status_t   m_tuser
);
  import nit_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_HDR_MARK  = 3'd1;
  localparam logic [2:0] PH_HDR_SPACE = 3'd2;
  localparam logic [2:0] PH_BIT_MARK  = 3'd3;
  localparam logic [2:0] PH_BIT_SPACE = 3'd4;
  localparam logic [2:0] PH_TRAILER   = 3'd5;
  localparam logic [2:0] PH_GAP       = 3'd6;

  dur_t        header_mark_us;
  dur_t        header_space_us;
  dur_t        bit_mark_us;
  dur_t        one_space_us;
  dur_t        zero_space_us;
  dur_t        trailer_mark_us;
  dur_t        repeat_gap_us;
  logic [2:0]  repeat_count;

  logic [2:0]  phase;
  dur_t        tick_counter;
  logic [4:0]  bit_position;
  logic [31:0] shift_code;
  logic [2:0]  repeats_left;
  logic        gap_enabled;

  logic [2:0]  phase_next;
  dur_t        tick_counter_next;
  logic [4:0]  bit_position_next;
  logic [31:0] shift_code_next;
  logic [2:0]  repeats_left_next;
  logic        gap_enabled_next;

  dur_t        tick_dec;
  dur_t        dur;
  logic        load;
  logic        end_frame;
  logic        busy;
  logic [2:0]  frames;
  status_t     status;
  logic        done;
  logic        led_next;

  // Configuration writes; the port never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_us  <= 17'd9000;
      header_space_us <= 17'd4500;
      bit_mark_us     <= 17'd560;
      one_space_us    <= 17'd1690;
      zero_space_us   <= 17'd560;
      trailer_mark_us <= 17'd560;
      repeat_gap_us   <= 17'd100000;
      repeat_count    <= 3'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADER_MARK:  header_mark_us  <= cfg_data;
        REG_HEADER_SPACE: header_space_us <= cfg_data;
        REG_BIT_MARK:     bit_mark_us     <= cfg_data;
        REG_ONE_SPACE:    one_space_us    <= cfg_data;
        REG_ZERO_SPACE:   zero_space_us   <= cfg_data;
        REG_TRAILER_MARK: trailer_mark_us <= cfg_data;
        REG_REPEAT_GAP:   repeat_gap_us   <= cfg_data;
        default:          repeat_count    <= cfg_data[2:0];
      endcase
    end
  end

  // A command is executed whenever the output register can take its result.
  assign cmd_pop = cmd_valid && (!m_tvalid || m_tready);
  assign busy    = (phase != PH_IDLE);
  assign tick_dec = tick_counter - 17'd1;
  assign frames  = (cmd.kind == CMD_TABLE) ? repeat_count : 3'd1;

  // Sequencer next state for the command at the head of the queue.
  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    bit_position_next = bit_position;
    shift_code_next   = shift_code;
    repeats_left_next = repeats_left;
    gap_enabled_next  = gap_enabled;
    dur       = '0;
    load      = 1'b0;
    end_frame = 1'b0;
    status    = ST_OK;
    done      = 1'b0;
    case (cmd.kind) inside
      CMD_TICK: begin
        if (busy) begin
          tick_counter_next = tick_dec;
          if (tick_dec == '0) begin
            unique case (phase)
              PH_HDR_MARK: begin
                phase_next = PH_HDR_SPACE;
                dur  = header_space_us;
                load = 1'b1;
              end
              PH_HDR_SPACE: begin
                bit_position_next = 5'd31;
                phase_next = PH_BIT_MARK;
                dur  = bit_mark_us;
                load = 1'b1;
              end
              PH_BIT_MARK: begin
                phase_next = PH_BIT_SPACE;
                dur  = shift_code[bit_position] ? one_space_us : zero_space_us;
                load = 1'b1;
              end
              PH_BIT_SPACE: begin
                if (bit_position == 5'd0) begin
                  phase_next = PH_TRAILER;
                  dur = trailer_mark_us;
                end else begin
                  bit_position_next = bit_position - 5'd1;
                  phase_next = PH_BIT_MARK;
                  dur = bit_mark_us;
                end
                load = 1'b1;
              end
              PH_TRAILER: begin
                if (gap_enabled && (repeat_gap_us != '0)) begin
                  phase_next = PH_GAP;
                  dur  = repeat_gap_us;
                  load = 1'b1;
                end else begin
                  end_frame = 1'b1;
                end
              end
              default: end_frame = 1'b1;
            endcase
          end
        end
      end
      CMD_RAW, CMD_TABLE: begin
        if (busy) begin
          status = ST_BUSY;
        end else begin
          status = ST_ACCEPT;
          shift_code_next   = cmd.code;
          repeats_left_next = (frames == 3'd0) ? 3'd1 : frames;
          gap_enabled_next  = (cmd.kind == CMD_TABLE);
          bit_position_next = 5'd0;
          phase_next = PH_HDR_MARK;
          dur  = header_mark_us;
          load = 1'b1;
        end
      end
      CMD_BAD_INDEX: status = busy ? ST_BUSY : ST_INVALID;
      default: status = ST_OK;
    endcase

    // End of a frame: start the next repeat or finish the request.
    if (end_frame) begin
      if (repeats_left > 3'd1) begin
        repeats_left_next = repeats_left - 3'd1;
        phase_next = PH_HDR_MARK;
        dur  = header_mark_us;
        load = 1'b1;
      end else begin
        repeats_left_next = 3'd0;
        phase_next        = PH_IDLE;
        tick_counter_next = '0;
        done              = 1'b1;
      end
    end

    // A zero duration still lasts one tick.
    if (load) begin
      tick_counter_next = (dur == '0) ? 17'd1 : dur;
    end
  end

  assign led_next = (phase_next == PH_HDR_MARK) || (phase_next == PH_BIT_MARK) ||
                    (phase_next == PH_TRAILER);

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_counter <= '0;
      bit_position <= '0;
      shift_code   <= '0;
      repeats_left <= '0;
      gap_enabled  <= 1'b0;
    end else if (cmd_pop) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bit_position <= bit_position_next;
      shift_code   <= shift_code_next;
      repeats_left <= repeats_left_next;
      gap_enabled  <= gap_enabled_next;
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      m_tdata <= {5'd0, done, (phase_next != PH_IDLE), led_next};
      m_tuser <= status;
    end
  end

  // The counter is zero exactly when the sequencer is idle.
  a_idle_counter: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_counter == '0))
    else $error("idle sequencer holds a nonzero tick count");

  a_run_counter: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (tick_counter != '0))
    else $error("running sequencer has a zero tick count");

  // A completion result always reports the block as no longer busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> !m_tdata[1])
    else $error("done reported while still busy");

  // An accepted request starts with the header mark lit.
  a_accept_mark: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_ACCEPT)) |-> (m_tdata[0] && m_tdata[1]))
    else $error("accepted request did not start a mark");

  // While the result waits, the sequencer does not advance.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(phase) && $stable(tick_counter))
    else $error("sequencer advanced while the result was stalled");

endmodule

@@ hdl/nec_ir_transmitter.sv @@
`timescale 1ns / 1ps
// Top level of the NEC IR transmitter: front end decoder, request queue and
// back end sequencer. Depends on nit_pkg, nit_front, nit_queue and nit_back.
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid / s_tready  tuser opcode, tdata index and raw code
//   m_*      out        m_tvalid / m_tready  tdata led, busy, done; tuser status
//   cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per clock is sustained while the queue is not full. A request is written
// into the queue at its accepting edge and its result is loaded into the output
// register once that register is free, and is held there until m_tready takes it.
// The queue holds FIFO_DEPTH requests, so input keeps flowing while a result
// waits on m_tready; s_tready drops only when the queue is full.
// Reset is synchronous; it restores the register defaults and idles the sequencer.
// cfg_ready is always high.
module nec_ir_transmitter #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,   // command_index[3:0], raw_code[35:4], zero pad
  input  nit_pkg::opcode_t    s_tuser,   // opcode[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // led_level[0], busy_res[1], done_res[2], zero pad
  output nit_pkg::status_t    m_tuser,   // status[1:0]
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  nit_pkg::reg_index_t cfg_index,
  input  nit_pkg::dur_t       cfg_data
);
  import nit_pkg::*;

  cmd_t             front_cmd;
  cmd_t             back_cmd;
  logic [CMD_W-1:0] queue_out;
  logic             queue_full;
  logic             queue_valid;
  logic             queue_pop;
  logic             push;
  logic [3:0]       pad_unused;

  assign pad_unused = s_tdata[39:36];
  assign s_tready  = !queue_full;
  assign push      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign back_cmd  = cmd_t'(queue_out);

  // Request decode and table lookup.
  nit_front u_front (
    .opcode        (s_tuser),
    .command_index (s_tdata[3:0]),
    .raw_code      (s_tdata[35:4]),
    .cmd           (front_cmd)
  );

  // Request queue between decode and the sequencer.
  nit_queue #(
    .WIDTH (CMD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (queue_out),
    .not_empty (queue_valid)
  );

  // Frame sequencer and result register.
  nit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (queue_valid),
    .cmd       (back_cmd),
    .cmd_pop   (queue_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // The decoder never sees pad bits; a request with any set is still legal.
  a_pad_ignored: assert property (@(posedge clk) disable iff (rst)
    (push && (pad_unused != 4'd0)) |-> (front_cmd.kind != CMD_BAD_INDEX) ||
    ({1'b0, s_tdata[3:0]} >= COMMAND_COUNT))
    else $error("pad bits changed the request decode");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push)
    else $error("request pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    queue_pop |-> queue_valid)
    else $error("sequencer popped an empty queue");

endmodule

@@ tb/sv/nec_ir_transmitter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the NEC IR transmitter: directed and random requests
// against a cycle-free predictor. Depends on nit_pkg and the nec_ir_transmitter RTL.
module nec_ir_transmitter_tb;
  import nit_pkg::*;

  localparam int   WATCHDOG_LIMIT  = 4000;
  localparam int   SETTLE_CYCLES   = 8;
  localparam int   HOLD_CYCLES     = 300;
  localparam int   RANDOM_PHASES   = 4;
  localparam int   PHASE_ITEMS     = 70;
  localparam dur_t DUR_MAX         = '1;
  localparam dur_t LONG_LEN        = 17'd12;

  // Command codes, entry 0 in the lowest bits.
  localparam logic [10*32-1:0] NEC_CODES = {
    32'h20DFC837, 32'h20DF48B7, 32'h20DF8877, 32'h20DFC03F, 32'h20DF40BF,
    32'h20DF0EF1, 32'h20DF0CF3, 32'h20DF08F7, 32'h20DF10EF, 32'h20DF10EF
  };

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_HDR_MARK, SEQ_HDR_SPACE, SEQ_BIT_MARK, SEQ_BIT_SPACE, SEQ_TRAILER, SEQ_GAP
  } seq_phase_t;

  typedef struct packed {
    logic    led;
    logic    busy;
    status_t status;
    logic    done;
  } led_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;  // command_index[3:0], raw_code[35:4], zero pad
  opcode_t     s_tuser   = OP_NOP;  // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;  // led_level[0], busy_res[1], done_res[2], zero pad
  status_t     m_tuser;  // status[1:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_index_t  cfg_index = REG_HEADER_MARK;
  dur_t        cfg_data  = '0;

  led_result_t pending_results[$];
  int          mismatches    = 0;
  int          stall_cycles  = 0;
  int          hold_request  = 0;
  bit          idle_en       = 1'b1;

  // Predicted timing registers.
  dur_t        hdr_mark_len, hdr_space_len, bit_mark_len, one_space_len;
  dur_t        zero_space_len, trailer_len, gap_len;
  logic [2:0]  frames_per_cmd;

  // Predicted sequencer state.
  seq_phase_t  seq_phase;
  dur_t        seq_count;
  logic [4:0]  seq_bit;
  logic [31:0] seq_code;
  logic [2:0]  frames_left;
  logic        gap_on;

  always #10 clk = ~clk;

  nec_ir_transmitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  task automatic reset_predictor();
    hdr_mark_len   = 17'd9000;
    hdr_space_len  = 17'd4500;
    bit_mark_len   = 17'd560;
    one_space_len  = 17'd1690;
    zero_space_len = 17'd560;
    trailer_len    = 17'd560;
    gap_len        = 17'd100000;
    frames_per_cmd = 3'd3;
    seq_phase      = SEQ_IDLE;
    seq_count      = '0;
    seq_bit        = '0;
    seq_code       = '0;
    frames_left    = '0;
    gap_on         = 1'b0;
  endtask

  function automatic void apply_setting(reg_index_t idx, dur_t value);
    case (idx)
      REG_HEADER_MARK:  hdr_mark_len   = value;
      REG_HEADER_SPACE: hdr_space_len  = value;
      REG_BIT_MARK:     bit_mark_len   = value;
      REG_ONE_SPACE:    one_space_len  = value;
      REG_ZERO_SPACE:   zero_space_len = value;
      REG_TRAILER_MARK: trailer_len    = value;
      REG_REPEAT_GAP:   gap_len        = value;
      default:          frames_per_cmd = value[2:0];
    endcase
  endfunction

  // A segment of length zero still lasts one tick.
  function automatic void enter_segment(seq_phase_t ph, dur_t len);
    seq_phase = ph;
    seq_count = (len == '0) ? dur_t'(1) : len;
  endfunction

  // Either restarts the header for the next repeat or ends the request.
  function automatic logic close_frame();
    if (frames_left > 3'd1) begin
      frames_left = frames_left - 3'd1;
      enter_segment(SEQ_HDR_MARK, hdr_mark_len);
      return 1'b0;
    end
    frames_left = '0;
    seq_phase   = SEQ_IDLE;
    seq_count   = '0;
    return 1'b1;
  endfunction

  function automatic logic advance_tick();
    if (seq_phase == SEQ_IDLE) return 1'b0;
    seq_count = seq_count - 1'b1;
    if (seq_count != '0) return 1'b0;
    case (seq_phase)
      SEQ_HDR_MARK: enter_segment(SEQ_HDR_SPACE, hdr_space_len);
      SEQ_HDR_SPACE: begin
        seq_bit = 5'd31;
        enter_segment(SEQ_BIT_MARK, bit_mark_len);
      end
      SEQ_BIT_MARK:
        enter_segment(SEQ_BIT_SPACE, seq_code[seq_bit] ? one_space_len : zero_space_len);
      SEQ_BIT_SPACE: begin
        if (seq_bit == 5'd0) begin
          enter_segment(SEQ_TRAILER, trailer_len);
        end else begin
          seq_bit = seq_bit - 5'd1;
          enter_segment(SEQ_BIT_MARK, bit_mark_len);
        end
      end
      SEQ_TRAILER: begin
        if (gap_on && gap_len != '0) enter_segment(SEQ_GAP, gap_len);
        else return close_frame();
      end
      default: return close_frame();
    endcase
    return 1'b0;
  endfunction

  function automatic void start_frame(logic [31:0] code, logic [2:0] frames, logic with_gap);
    seq_code    = code;
    frames_left = (frames == 3'd0) ? 3'd1 : frames;
    gap_on      = with_gap;
    seq_bit     = '0;
    enter_segment(SEQ_HDR_MARK, hdr_mark_len);
  endfunction

  // Busy is checked ahead of the index range.
  function automatic led_result_t predict_led(opcode_t op, logic [3:0] idx, logic [31:0] code);
    led_result_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_TICK: r.done = advance_tick();
      OP_TABLE, OP_RAW: begin
        if (seq_phase != SEQ_IDLE) begin
          r.status = ST_BUSY;
        end else if (op == OP_RAW) begin
          start_frame(code, 3'd1, 1'b0);
          r.status = ST_ACCEPT;
        end else if ({1'b0, idx} >= COMMAND_COUNT) begin
          r.status = ST_INVALID;
        end else begin
          start_frame(NEC_CODES[int'(idx)*32 +: 32], frames_per_cmd, 1'b1);
          r.status = ST_ACCEPT;
        end
      end
      default: ;
    endcase
    r.led  = (seq_phase == SEQ_HDR_MARK) || (seq_phase == SEQ_BIT_MARK) ||
             (seq_phase == SEQ_TRAILER);
    r.busy = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offers one request after a random gap; valid stays high on back-to-back requests.
  task automatic send_item(input opcode_t op, input logic [3:0] idx, input logic [31:0] code);
    int gap;
    gap = idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, code, idx};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_led(op, idx, code));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 4'($urandom()), $urandom());
  endtask

  // Ticks until the predicted sequencer has gone idle.
  task automatic run_out();
    while (seq_phase != SEQ_IDLE) send_tick();
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input reg_index_t idx, input dur_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_setting(idx, value);
    @(posedge clk);
  endtask

  task automatic configure_timing(input dur_t hm, input dur_t hs, input dur_t bm,
                                  input dur_t os, input dur_t zs, input dur_t tm,
                                  input dur_t gap, input dur_t count);
    write_setting(REG_HEADER_MARK, hm);
    write_setting(REG_HEADER_SPACE, hs);
    write_setting(REG_BIT_MARK, bm);
    write_setting(REG_ONE_SPACE, os);
    write_setting(REG_ZERO_SPACE, zs);
    write_setting(REG_TRAILER_MARK, tm);
    write_setting(REG_REPEAT_GAP, gap);
    write_setting(REG_REPEAT_COUNT, count);
  endtask

  function automatic dur_t pick_len();
    return ($urandom_range(0, 9) == 0) ? dur_t'(0) : dur_t'($urandom_range(1, 3));
  endfunction

  // Result sink: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = idle_en ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    led_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none actual %h/%0d",
                 $time, m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("led_level", want.led, m_tdata[0]);
        check_field("busy_res", want.busy, m_tdata[1]);
        check_field("status", want.status, m_tuser);
        check_field("done_res", want.done, m_tdata[2]);
      end
    end
  end

  // Ends the run when no handshake of any kind has happened for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Requests at the reset timing that leave an idle block idle.
  task automatic test_default_frame();
    idle_en = 1'b1;
    send_item(OP_NOP, 4'hF, 32'hFFFF_FFFF);
    send_item(OP_TICK, 4'h0, 32'h0);
    send_item(OP_TABLE, 4'd10, 32'h0);
    send_item(OP_TABLE, 4'd15, 32'h0);
    send_item(OP_TICK, 4'hF, 32'hFFFF_FFFF);
    send_item(OP_NOP, 4'h0, 32'h0);
    wait_drain();
  endtask

  // Zero durations, zero repeat count and zero gap, then back-to-back repeats.
  task automatic test_zero_settings();
    idle_en = 1'b1;
    configure_timing('0, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_TABLE, 4'd9, 32'h0);
    send_item(OP_TABLE, 4'd12, 32'h0);
    send_item(OP_NOP, 4'd3, 32'h1234_5678);
    run_out();
    send_item(OP_RAW, 4'h0, 32'h0);
    run_out();
    wait_drain();
    configure_timing(17'd1, '0, 17'd1, 17'd2, '0, 17'd1, '0, 17'd2);
    send_item(OP_TABLE, 4'd0, 32'h0);
    send_item(OP_RAW, 4'h0, 32'hFFFF_FFFF);
    send_item(OP_RAW, 4'h0, 32'h0);
    run_out();
    wait_drain();
  endtask

  // Mostly well-formed requests with random content, ticks while busy, some noise.
  task automatic test_random_traffic();
    int pick;
    opcode_t op;
    logic [3:0] idx;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      configure_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                       pick_len(), dur_t'($urandom_range(0, 4)),
                       dur_t'($urandom_range(0, 3)));
      idle_en = (ph != 1);
      if (ph == 3) hold_request = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (seq_phase == SEQ_IDLE) op = (pick < 80) ? OP_RAW : (pick < 90) ? OP_TICK : OP_NOP;
        else op = (pick < 90) ? OP_TICK : (pick < 96) ? OP_RAW : OP_NOP;
        if (op == OP_RAW && $urandom_range(0, 1)) op = OP_TABLE;
        idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
        send_item(op, idx, $urandom());
      end
      run_out();
      wait_drain();
    end
  endtask

  // Longer header and trailer marks on a raw frame; the gap register sits at its top
  // value, which a raw frame never uses.
  task automatic test_long_segments();
    idle_en = 1'b1;
    configure_timing(LONG_LEN, 17'd1, 17'd1, 17'd2, 17'd1, LONG_LEN, DUR_MAX, 17'd1);
    send_item(OP_RAW, 4'd8, 32'h20DF_48B7);
    idle_en = 1'b0;
    run_out();
    wait_drain();
  endtask

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_default_frame();
    test_zero_settings();
    test_random_traffic();
    test_long_segments();
    wait_drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
